>>> rtl/shipick_pkg.sv
// Shared constants, types and helpers for the seeded hash index picker.
package shipick_pkg;

    localparam logic [63:0] MIX_ADD  = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL2 = 64'h94d049bb133111eb;

    localparam logic [63:0] SALT_NORTH = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] SALT_SOUTH = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] SALT_EAST  = 64'h94d049bb133111eb;
    localparam logic [63:0] SALT_WEST  = 64'h1234567890abcdef;

    localparam logic [2:0] DIR_NORTH = 3'd1;
    localparam logic [2:0] DIR_SOUTH = 3'd2;
    localparam logic [2:0] DIR_EAST  = 3'd3;
    localparam logic [2:0] DIR_WEST  = 3'd4;

    localparam int MOD_BITS_PER_STAGE = 4;
    localparam int MOD_STAGES         = 64 / MOD_BITS_PER_STAGE;
    localparam int MIX_STAGES         = 5;

    typedef struct packed {
        logic [63:0] addend;
        logic [10:0] modulus;
        logic        pool_zero;
    } side_t;

    // salt plus the mixer's leading constant
    function automatic logic [63:0] salt_plus_add(input logic [2:0] dir);
        logic [63:0] s;
        unique case (dir)
            DIR_SOUTH: s = SALT_SOUTH;
            DIR_EAST:  s = SALT_EAST;
            DIR_WEST:  s = SALT_WEST;
            default:   s = SALT_NORTH;
        endcase
        return s + MIX_ADD;
    endfunction

    // restoring remainder, a few dividend bits per call
    function automatic logic [10:0] rem_step(input logic [10:0] r_in,
                                             input logic [MOD_BITS_PER_STAGE-1:0] bits,
                                             input logic [10:0] m);
        logic [11:0] r;
        r = {1'b0, r_in};
        for (int i = MOD_BITS_PER_STAGE - 1; i >= 0; i--) begin
            r = {r[10:0], bits[i]};
            if (r >= {1'b0, m})
            begin
                r = r - {1'b0, m};
            end
        end
        return r[10:0];
    endfunction

endpackage

>>> rtl/shipick_mix.sv
// Five-stage pipelined SplitMix64 finalizer with a preceding add.
module shipick_mix (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [63:0]          in_v,
    input  logic [63:0]          in_add,
    input  shipick_pkg::side_t   in_side,
    output logic                 out_valid,
    output logic [63:0]          out_v,
    output shipick_pkg::side_t   out_side
);

    logic [shipick_pkg::MIX_STAGES-1:0] vld_reg;
    shipick_pkg::side_t side_reg [shipick_pkg::MIX_STAGES];

    logic [63:0] x_reg, x_next;
    logic [63:0] p0a_reg;
    logic [31:0] p1a_reg, p2a_reg;
    logic [63:0] y_reg, y_next, ysum;
    logic [63:0] p0b_reg;
    logic [31:0] p1b_reg, p2b_reg;
    logic [63:0] z_reg, z_next, zsum;
    logic [63:0] s;

    always_comb
    begin
        s      = in_v + in_add;
        x_next = s ^ (s >> 30);
        ysum   = p0a_reg + {p1a_reg + p2a_reg, 32'b0};
        y_next = ysum ^ (ysum >> 27);
        zsum   = p0b_reg + {p1b_reg + p2b_reg, 32'b0};
        z_next = zsum ^ (zsum >> 31);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[shipick_pkg::MIX_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= in_side;
        for (int i = 1; i < shipick_pkg::MIX_STAGES; i++) begin
            side_reg[i] <= side_reg[i-1];
        end
        x_reg   <= x_next;
        p0a_reg <= x_reg[31:0] * shipick_pkg::MIX_MUL1[31:0];
        p1a_reg <= 32'(x_reg[63:32] * shipick_pkg::MIX_MUL1[31:0]);
        p2a_reg <= 32'(x_reg[31:0] * shipick_pkg::MIX_MUL1[63:32]);
        y_reg   <= y_next;
        p0b_reg <= y_reg[31:0] * shipick_pkg::MIX_MUL2[31:0];
        p1b_reg <= 32'(y_reg[63:32] * shipick_pkg::MIX_MUL2[31:0]);
        p2b_reg <= 32'(y_reg[31:0] * shipick_pkg::MIX_MUL2[63:32]);
        z_reg   <= z_next;
    end

    assign out_valid = vld_reg[shipick_pkg::MIX_STAGES-1];
    assign out_v     = z_reg;
    assign out_side  = side_reg[shipick_pkg::MIX_STAGES-1];

endmodule

>>> rtl/shipick_mod.sv
// Pipelined 64-bit by 11-bit remainder, four dividend bits per stage.
module shipick_mod (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [63:0]         in_h,
    input  shipick_pkg::side_t  in_side,
    output logic                out_valid,
    output logic [9:0]          out_index
);

    localparam int NS = shipick_pkg::MOD_STAGES;
    localparam int BP = shipick_pkg::MOD_BITS_PER_STAGE;

    logic [NS-1:0] vld_reg;
    logic [63:0]   h_reg [NS];
    logic [10:0]   r_reg [NS];
    logic [10:0]   m_reg [NS];
    logic [NS-1:0] zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg[0]    <= in_h << BP;
        m_reg[0]    <= in_side.modulus;
        zero_reg[0] <= in_side.pool_zero;
        r_reg[0]    <= shipick_pkg::rem_step(11'd0, in_h[63 -: BP], in_side.modulus);
        for (int i = 1; i < NS; i++) begin
            h_reg[i]    <= h_reg[i-1] << BP;
            m_reg[i]    <= m_reg[i-1];
            zero_reg[i] <= zero_reg[i-1];
            r_reg[i]    <= shipick_pkg::rem_step(r_reg[i-1], h_reg[i-1][63 -: BP],
                                                 m_reg[i-1]);
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_index = zero_reg[NS-1] ? 10'd0 : r_reg[NS-1][9:0];

endmodule

>>> rtl/seeded_hash_index_picker_unit.sv
// Top level of the seeded hash index picker.
// One request is taken every clock cycle (busy stays low); its index appears
// on chosen_index with done high after the transfer passes through one
// input stage, two five-stage SplitMix64 pipelines built from 32x32 partial
// products, and a sixteen-stage remainder pipeline that retires four hash
// bits per stage. Results cannot be held off, so nothing ever stalls.
// world_seed is to be written through cfg_valid/cfg_ready only while no request
// is in flight; the block does not enforce this, and cfg_ready is always high.
module seeded_hash_index_picker_unit #(
    parameter int CANVAS_TILES = 1024,
    parameter int POOL_MAX     = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] tile_x,
    input  logic [15:0] tile_y,
    input  logic [2:0]  direction,
    input  logic [10:0] pool_size,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cfg_data,
    output logic        done,
    output logic [9:0]  chosen_index
);

    localparam int LATENCY = 1 + 2 * shipick_pkg::MIX_STAGES + shipick_pkg::MOD_STAGES;

    logic [63:0] seed_reg;
    logic        in_vld_reg;
    logic [63:0] key_reg, key_next;
    shipick_pkg::side_t side_reg, side_next;
    logic [32:0] prod;

    logic               m1_valid, m2_valid;
    logic [63:0]        m1_v, m2_v;
    shipick_pkg::side_t m1_side, m2_side;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        prod     = 33'(tile_x) * 33'(CANVAS_TILES);
        key_next = 64'(prod) + 64'(tile_y);
        side_next.addend    = shipick_pkg::salt_plus_add(direction) + seed_reg;
        side_next.pool_zero = (pool_size == 11'd0);
        if (32'(pool_size) > 32'(POOL_MAX))
        begin
            side_next.modulus = 11'(POOL_MAX);
        end
        else
        begin
            side_next.modulus = pool_size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg   <= '0;
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= start && !busy;
            if (cfg_valid && cfg_ready)
            begin
                seed_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        side_reg <= side_next;
    end

    shipick_mix u_mix_pos (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_vld_reg),
        .in_v      (key_reg),
        .in_add    (shipick_pkg::MIX_ADD),
        .in_side   (side_reg),
        .out_valid (m1_valid),
        .out_v     (m1_v),
        .out_side  (m1_side)
    );

    shipick_mix u_mix_seed (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m1_valid),
        .in_v      (m1_v),
        .in_add    (m1_side.addend),
        .in_side   (m1_side),
        .out_valid (m2_valid),
        .out_v     (m2_v),
        .out_side  (m2_side)
    );

    shipick_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m2_valid),
        .in_h      (m2_v),
        .in_side   (m2_side),
        .out_valid (done),
        .out_index (chosen_index)
    );

    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result missing after fixed latency");

    a_empty_pool: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && pool_size == 11'd0) |-> ##LATENCY (chosen_index == 10'd0))
        else $error("empty pool gave nonzero index");

    a_unit_pool: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && pool_size == 11'd1) |-> ##LATENCY (chosen_index == 10'd0))
        else $error("pool of one gave nonzero index");

endmodule

>>> tb/seeded_hash_index_picker_unit_tb.sv
// Self-checking testbench for the seeded hash index picker: predicted indexes vs. DUT output.
`timescale 1ns / 100ps

module seeded_hash_index_picker_unit_tb;

    localparam int CANVAS = 1024;
    localparam int POOL_LIMIT = 1024;
    localparam int LATENCY = 27;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 1600;

    typedef struct packed {
        logic [15:0] tx;
        logic [15:0] ty;
        logic [2:0]  dir;
        logic [10:0] pool;
    } request_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [15:0] tile_x = '0;
    logic [15:0] tile_y = '0;
    logic [2:0]  direction = '0;
    logic [10:0] pool_size = 11'd1;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [63:0] cfg_data = '0;
    logic        done;
    logic [9:0]  chosen_index;

    request_t    pending_reqs[$];
    logic [9:0]  index_queue[$];
    logic [63:0] seed_model = '0;
    logic [63:0] seed_next;
    logic        seed_write_req = 1'b0;
    bit          seed_write_done = 1'b0;
    int          error_count = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          sent_count = 0;
    int          checked_count = 0;
    int          seed_writes = 0;

    seeded_hash_index_picker_unit i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .tile_x(tile_x),
        .tile_y(tile_y),
        .direction(direction),
        .pool_size(pool_size),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .done(done),
        .chosen_index(chosen_index)
    );

    always #6 clk = ~clk;

    function automatic logic [63:0] splitmix(input logic [63:0] v);
        logic [63:0] t;
        t = v + 64'h9e3779b97f4a7c15;
        t = (t ^ (t >> 30)) * 64'hbf58476d1ce4e5b9;
        t = (t ^ (t >> 27)) * 64'h94d049bb133111eb;
        return t ^ (t >> 31);
    endfunction

    function automatic logic [9:0] pick_index(input request_t r, input logic [63:0] seed);
        logic [63:0] h;
        logic [63:0] salt;
        logic [63:0] m;
        case (r.dir)
            shipick_pkg::DIR_SOUTH: salt = shipick_pkg::SALT_SOUTH;
            shipick_pkg::DIR_EAST:  salt = shipick_pkg::SALT_EAST;
            shipick_pkg::DIR_WEST:  salt = shipick_pkg::SALT_WEST;
            default:                salt = shipick_pkg::SALT_NORTH;
        endcase
        h = splitmix(64'(r.tx) * CANVAS + 64'(r.ty));
        h = splitmix(seed + h + salt);
        if (r.pool == 0)
            return '0;
        m = (r.pool > POOL_LIMIT) ? 64'(POOL_LIMIT) : 64'(r.pool);
        return 10'(h % m);
    endfunction

    function automatic request_t random_request();
        request_t r;
        r.tx = 16'($urandom);
        r.ty = 16'($urandom);
        r.dir = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 5))
            0: r.pool = 11'($urandom_range(0, 2047));
            1: r.pool = 11'($urandom_range(1, 8));
            default: r.pool = 11'($urandom_range(1, 1024));
        endcase
        return r;
    endfunction

    task automatic add_request(input request_t req);
        pending_reqs.insert(pending_reqs.size(), req);
    endtask

    // driver
    always @(negedge clk) begin
        if (rst_n) begin
            if (seed_write_req && !cfg_valid && pending_reqs.size() == 0 && !start) begin
                cfg_valid <= 1'b1;
                cfg_data <= seed_next;
            end else if (cfg_valid) begin
                cfg_valid <= 1'b0;
            end

            if (start && !busy) begin
                // previous transfer taken at the last rising edge
            end
            if (!seed_write_req && pending_reqs.size() > 0 && (!start || !busy)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    start <= 1'b0;
                end else begin
                    tile_x <= pending_reqs[0].tx;
                    tile_y <= pending_reqs[0].ty;
                    direction <= pending_reqs[0].dir;
                    pool_size <= pending_reqs[0].pool;
                    start <= 1'b1;
                    void'(pending_reqs.pop_front());
                    if (burst_left > 0) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        burst_left <= $urandom_range(0, 40);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end else if (!start || !busy) begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                seed_model <= cfg_data;
                seed_write_done <= 1'b1;
                seed_writes++;
            end
            if (start && !busy) begin
                index_queue.insert(index_queue.size(),
                                   pick_index({tile_x, tile_y, direction, pool_size},
                                              seed_model));
                sent_count++;
            end
            if (done) begin
                if (index_queue.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d",
                             $time, chosen_index);
                    error_count++;
                end else begin
                    if (chosen_index !== index_queue[0]) begin
                        $display("%0t: chosen_index mismatch, expected %0d, actual %0d",
                                 $time, index_queue[0], chosen_index);
                        error_count++;
                    end
                    void'(index_queue.pop_front());
                    checked_count++;
                end
            end
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[seeded_hash_index_picker_unit] ERROR");
                $finish;
            end
        end
    end

    task automatic write_seed(input logic [63:0] value);
        wait (pending_reqs.size() == 0);
        @(negedge clk);
        wait (!start && index_queue.size() == 0);
        repeat (LATENCY + 2) @(posedge clk);
        seed_next = value;
        seed_write_done = 1'b0;
        seed_write_req = 1'b1;
        wait (seed_write_done);
        @(negedge clk);
        seed_write_req = 1'b0;
    endtask

    task automatic queue_phase(input int count);
        for (int i = 0; i < count; i++)
            add_request(random_request());
    endtask

    initial begin
        request_t r;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes, every direction, empty and oversized pools
        for (int d = 0; d < 8; d++) begin
            r = '{tx: 16'hffff, ty: 16'hffff, dir: 3'(d), pool: 11'd1024};
            add_request(r);
        end
        add_request('{tx: 16'h0, ty: 16'h0, dir: shipick_pkg::DIR_NORTH, pool: 11'd1});
        add_request('{tx: 16'h0, ty: 16'h0, dir: shipick_pkg::DIR_WEST, pool: 11'd0});
        add_request('{tx: 16'h5555, ty: 16'haaaa, dir: shipick_pkg::DIR_EAST,
                      pool: 11'd2047});
        add_request('{tx: 16'haaaa, ty: 16'h5555, dir: shipick_pkg::DIR_SOUTH,
                      pool: 11'd1025});
        add_request('{tx: 16'h0, ty: 16'hffff, dir: 3'd7, pool: 11'd1023});
        add_request('{tx: 16'hffff, ty: 16'h0, dir: 3'd0, pool: 11'd2});
        add_request('{tx: 16'h8000, ty: 16'h8000, dir: 3'd5, pool: 11'd512});
        add_request('{tx: 16'h1, ty: 16'h1, dir: 3'd6, pool: 11'd3});
        queue_phase(RANDOM_ITEMS / 4);

        write_seed(64'hffffffffffffffff);
        queue_phase(RANDOM_ITEMS / 4);
        write_seed({$urandom, $urandom});
        queue_phase(RANDOM_ITEMS / 4);
        write_seed(64'h0000000000000001);
        queue_phase(RANDOM_ITEMS / 8);
        write_seed(64'h0);
        queue_phase(RANDOM_ITEMS / 8);

        wait (pending_reqs.size() == 0);
        @(negedge clk);
        wait (!start && index_queue.size() == 0);
        repeat (LATENCY + 5) @(posedge clk);
        $display("Covered %0d requests over %0d seed settings, %0d indexes checked.",
                 sent_count, seed_writes + 1, checked_count);
        if (error_count == 0 && index_queue.size() == 0)
            $display("[seeded_hash_index_picker_unit] OK");
        else
            $display("[seeded_hash_index_picker_unit] ERROR");
        $finish;
    end

endmodule

>>> seeded_hash_index_picker_unit.f
rtl/shipick_pkg.sv
rtl/shipick_mix.sv
rtl/shipick_mod.sv
rtl/seeded_hash_index_picker_unit.sv
tb/seeded_hash_index_picker_unit_tb.sv
